// ===== src/ntpe_pkg.sv =====
// Package for the node table: transfer payload types, function codes, FSM states.
// No dependencies.
`default_nettype none
package ntpe_pkg;

    localparam logic [2:0] FN_UPSERT    = 3'd0;
    localparam logic [2:0] FN_PHASE     = 3'd1;
    localparam logic [2:0] FN_COMMIT    = 3'd2;
    localparam logic [2:0] FN_LOOKUP    = 3'd3;
    localparam logic [2:0] FN_TAKE_NTH  = 3'd4;
    localparam logic [2:0] FN_SET_ROUTE = 3'd5;
    localparam logic [2:0] FN_SET_POS   = 3'd6;
    localparam logic [2:0] FN_NOP       = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] node_id;
        logic [63:0] info_data;
        logic [63:0] route_data;
        logic [63:0] position_data;
        logic [6:0]  index;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] out_node_id;
        logic [63:0] out_info;
        logic [63:0] out_route;
        logic [63:0] out_position;
        logic [6:0]  live_count;
        logic [31:0] change_count;
        logic [31:0] commit_count;
        logic        sweep_done;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_WRITE,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

// ===== src/node_table_phase_evict.sv =====
// Node table with phase-tagged eviction: top level, sequencer, slot stores.
// Depends on ntpe_pkg.
//
// Usage: one request channel (in_valid/in_stall, payload in_data) and one
// response channel (out_valid/out_stall, payload out_data). Every request
// gives exactly one response.
// A request is walked over the slots one per cycle with a single shared
// compare unit that works on the registered slot read data; after the
// scan come a memory read state (ST_READ) and a write state (ST_WRITE),
// then the response is registered. One request is in flight at a time,
// so a new request is taken only once the last response has left.
// in_stall is high while a request is in progress or its response waits.
// While out_stall is high the response holds steady in its register.
// Reset clears all used bits, the counters, and sets the phase to one;
// slot payload memories are not cleared since only live slots are read.
`default_nettype none
module node_table_phase_evict #(
    parameter int SLOTS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire ntpe_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output ntpe_pkg::rsp_t     out_data
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [31:0] key_mem   [SLOTS];
    logic [31:0] phase_mem [SLOTS];
    logic [63:0] info_mem  [SLOTS];
    logic [63:0] route_mem [SLOTS];
    logic [63:0] pos_mem   [SLOTS];
    logic [SLOTS-1:0] used_reg, used_next;

    ntpe_pkg::state_t state_reg, state_next;
    ntpe_pkg::req_t req_reg;
    logic [CW-1:0] ptr_reg;
    logic [IW-1:0] idx;
    logic [31:0] phase_now_reg, writes_reg, sweeps_reg;
    logic        swept_reg;
    logic [CW-1:0] live_reg;
    logic [6:0]    nth_reg;
    logic        hit_reg, empty_fnd_reg, vict_fnd_reg;
    logic [IW-1:0] hit_reg_i, empty_reg_i, vict_reg_i;
    logic [31:0] vphase_reg;
    logic [31:0] key_rd, phase_rd;
    logic [IW-1:0] tgt;
    logic        do_write, tgt_ok;
    ntpe_pkg::rsp_t rsp_reg;
    logic [IW-1:0] scan_i;
    logic          scan_v;
    logic          scan_used;

    assign idx = ptr_reg[IW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntpe_pkg::ST_IDLE:
                if (in_valid) state_next = ntpe_pkg::ST_SCAN;
            ntpe_pkg::ST_SCAN:
                if (ptr_reg == CW'(SLOTS)) state_next = ntpe_pkg::ST_READ;
            ntpe_pkg::ST_READ:  state_next = ntpe_pkg::ST_WRITE;
            ntpe_pkg::ST_WRITE: state_next = ntpe_pkg::ST_RESP;
            ntpe_pkg::ST_RESP:
                if (!out_stall) state_next = ntpe_pkg::ST_IDLE;
            default: state_next = ntpe_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = (state_reg != ntpe_pkg::ST_IDLE);
        out_valid = (state_reg == ntpe_pkg::ST_RESP);
        out_data  = rsp_reg;
    end

    // target slot and write decision
    always_comb
    begin
        tgt = hit_reg_i;
        tgt_ok = hit_reg;
        do_write = 1'b0;
        case (req_reg.func)
            ntpe_pkg::FN_UPSERT:
            begin
                if (!hit_reg) tgt = empty_fnd_reg ? empty_reg_i : vict_reg_i;
                tgt_ok = hit_reg || empty_fnd_reg || vict_fnd_reg;
                do_write = (req_reg.node_id != 32'd0) && tgt_ok;
            end
            ntpe_pkg::FN_SET_ROUTE, ntpe_pkg::FN_SET_POS:
                do_write = (req_reg.node_id != 32'd0) && hit_reg;
            default: do_write = 1'b0;
        endcase
    end

    // used bits; the sweep clears the slot whose read data is at hand, an upsert sets its target
    always_comb
    begin
        used_next = used_reg;
        if (scan_v && req_reg.func == ntpe_pkg::FN_COMMIT
            && scan_used && phase_rd != phase_now_reg)
            used_next[scan_i] = 1'b0;
        if (state_reg == ntpe_pkg::ST_WRITE && req_reg.func == ntpe_pkg::FN_UPSERT
            && do_write)
            used_next[tgt] = 1'b1;
    end

    // slot memories: async-free reads for the scan column, registered per cycle; slot writes and the response register
    always_ff @(posedge clk)
    begin
        key_rd   <= key_mem[idx];
        phase_rd <= phase_mem[idx];
        if (state_reg == ntpe_pkg::ST_WRITE && do_write)
        begin
            if (req_reg.func == ntpe_pkg::FN_UPSERT)
            begin
                key_mem[tgt]   <= req_reg.node_id;
                phase_mem[tgt] <= phase_now_reg;
                info_mem[tgt]  <= req_reg.info_data;
                route_mem[tgt] <= req_reg.route_data;
                pos_mem[tgt]   <= req_reg.position_data;
            end
            else if (req_reg.func == ntpe_pkg::FN_SET_ROUTE)
                route_mem[tgt] <= req_reg.route_data;
            else
                pos_mem[tgt] <= req_reg.position_data;
        end
        if (state_reg == ntpe_pkg::ST_READ)
        begin
            rsp_reg.out_node_id  <= key_mem[hit_reg_i];
            rsp_reg.out_info     <= info_mem[hit_reg_i];
            rsp_reg.out_route    <= route_mem[hit_reg_i];
            rsp_reg.out_position <= pos_mem[hit_reg_i];
        end
        if (state_reg == ntpe_pkg::ST_WRITE)
        begin
            if (!(hit_reg && (req_reg.func == ntpe_pkg::FN_LOOKUP
                              || req_reg.func == ntpe_pkg::FN_TAKE_NTH)))
            begin
                rsp_reg.out_node_id  <= '0;
                rsp_reg.out_info     <= '0;
                rsp_reg.out_route    <= '0;
                rsp_reg.out_position <= '0;
                rsp_reg.found        <= 1'b0;
            end
            else
                rsp_reg.found <= 1'b1;
            rsp_reg.live_count   <= 7'(live_reg + CW'(do_write && !hit_reg
                                    && empty_fnd_reg
                                    && req_reg.func == ntpe_pkg::FN_UPSERT));
            rsp_reg.change_count <= writes_reg + 32'(do_write
                                    || req_reg.func == ntpe_pkg::FN_COMMIT);
            rsp_reg.commit_count <= sweeps_reg + 32'(req_reg.func == ntpe_pkg::FN_COMMIT);
            rsp_reg.sweep_done   <= swept_reg || (req_reg.func == ntpe_pkg::FN_COMMIT);
        end
    end

    // The compare works on the slot read in the cycle before: ptr_reg addresses
    // slot idx, key_rd/phase_rd show slot scan_i. The scan state at
    // ptr_reg == SLOTS only finishes the compare of the last slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_v <= 1'b0;
            scan_i <= '0;
            scan_used <= 1'b0;
        end
        else
        begin
            scan_v    <= (state_reg == ntpe_pkg::ST_SCAN) && (ptr_reg != CW'(SLOTS));
            scan_i    <= idx;
            scan_used <= used_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntpe_pkg::ST_IDLE;
            used_reg      <= '0;
            phase_now_reg <= 32'd1;
            writes_reg    <= '0;
            sweeps_reg    <= '0;
            swept_reg     <= 1'b0;
            ptr_reg       <= '0;
            live_reg      <= '0;
            nth_reg       <= '0;
            hit_reg       <= 1'b0;
            empty_fnd_reg <= 1'b0;
            vict_fnd_reg  <= 1'b0;
            hit_reg_i     <= '0;
            empty_reg_i   <= '0;
            vict_reg_i    <= '0;
            vphase_reg    <= '0;
            req_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            case (state_reg)
                ntpe_pkg::ST_IDLE:
                begin
                    ptr_reg       <= '0;
                    live_reg      <= '0;
                    nth_reg       <= '0;
                    hit_reg       <= 1'b0;
                    empty_fnd_reg <= 1'b0;
                    vict_fnd_reg  <= 1'b0;
                    if (in_valid) req_reg <= in_data;
                end
                ntpe_pkg::ST_SCAN:
                    if (ptr_reg != CW'(SLOTS)) ptr_reg <= ptr_reg + 1'b1;
                ntpe_pkg::ST_WRITE:
                begin
                    if (do_write || req_reg.func == ntpe_pkg::FN_COMMIT)
                        writes_reg <= writes_reg + 32'd1;
                    if (req_reg.func == ntpe_pkg::FN_COMMIT)
                    begin
                        sweeps_reg <= sweeps_reg + 32'd1;
                        swept_reg  <= 1'b1;
                    end
                    if (req_reg.func == ntpe_pkg::FN_PHASE)
                        phase_now_reg <= phase_now_reg + 32'd1;
                end
                default: ;
            endcase
            // shared compare unit, one slot per cycle
            if (scan_v)
            begin
                if (scan_used)
                begin
                    if (!(req_reg.func == ntpe_pkg::FN_COMMIT
                          && phase_rd != phase_now_reg))
                        live_reg <= live_reg + 1'b1;
                    if (req_reg.func == ntpe_pkg::FN_TAKE_NTH)
                    begin
                        if (!hit_reg && nth_reg == req_reg.index)
                        begin
                            hit_reg   <= 1'b1;
                            hit_reg_i <= scan_i;
                        end
                        nth_reg <= nth_reg + 1'b1;
                    end
                    else if (!hit_reg && key_rd == req_reg.node_id)
                    begin
                        hit_reg   <= 1'b1;
                        hit_reg_i <= scan_i;
                    end
                    if (!vict_fnd_reg || phase_rd < vphase_reg)
                    begin
                        vict_fnd_reg <= 1'b1;
                        vict_reg_i   <= scan_i;
                        vphase_reg   <= phase_rd;
                    end
                end
                else if (!empty_fnd_reg)
                begin
                    empty_fnd_reg <= 1'b1;
                    empty_reg_i   <= scan_i;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/ntpe_check.sv =====
// Port-level checker for the node table, bound to the top level.
// Depends on ntpe_pkg.
`default_nettype none
module ntpe_check (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_stall,
    input wire ntpe_pkg::req_t in_data,
    input wire logic           out_valid,
    input wire logic           out_stall,
    input wire ntpe_pkg::rsp_t out_data
);
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open while response pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled response changed");
    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.live_count <= 7'd64) else $error("live count too big");
    a_nf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.out_node_id == 32'd0)
        else $error("not found result with key");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall) else $error("request not taken");
endmodule

bind node_table_phase_evict ntpe_check u_check (.*);
`default_nettype wire
